@@ rtl/utfq_pkg.sv @@
// shared constants, types and codes of the uart transmit filter queue
`timescale 1ns / 1ps
`default_nettype none

package utfq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int MAX_BURST   = 16;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int BURST_W = $clog2(MAX_BURST + 1);

  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [BURST_W-1:0]  burst_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PHASE_W-1:0]  phase_t;

  // result status codes
  localparam status_t ST_QUEUED   = 3'd0;
  localparam status_t ST_FILTERED = 3'd1;
  localparam status_t ST_REJECTED = 3'd2;
  localparam status_t ST_DISABLED = 3'd3;
  localparam status_t ST_SENT     = 3'd4;
  localparam status_t ST_NONE     = 3'd5;

  // input actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET  = 1'd1;

  localparam logic [CFG_DATA_W-1:0] AUTO_BUDGET_RST = 5'd16;

  // escape filter phases
  localparam phase_t PH_NONE = 2'd0;
  localparam phase_t PH_ESC  = 2'd1;
  localparam phase_t PH_CSI  = 2'd2;

  // filter byte constants
  localparam byte_t ESC_BYTE     = 8'h1B;
  localparam byte_t CSI_OPEN     = 8'h5B;
  localparam byte_t CSI_END_LOW  = 8'h40;
  localparam byte_t CSI_END_HIGH = 8'h7E;
  localparam byte_t PRINT_LOW    = 8'h20;
  localparam byte_t LINE_FEED    = 8'h0A;

  // filter control from the sequencer
  typedef struct packed {
    logic  upd;
    byte_t data;
  } filt_req_t;

endpackage

`default_nettype wire

@@ rtl/utfq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module utfq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/utfq_filter.sv @@
// escape filter: phase register and byte classification
`timescale 1ns / 1ps
`default_nettype none

module utfq_filter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire utfq_pkg::filt_req_t  req,
  output logic                      pass
);

  utfq_pkg::phase_t phase_r;
  utfq_pkg::phase_t phase_nxt;
  utfq_pkg::byte_t  b;

  assign b = req.data;

  always_comb begin
    pass      = 1'b0;
    phase_nxt = utfq_pkg::PH_NONE;
    unique case (phase_r)
      utfq_pkg::PH_ESC: begin
        phase_nxt = (b == utfq_pkg::CSI_OPEN) ? utfq_pkg::PH_CSI : utfq_pkg::PH_NONE;
      end
      utfq_pkg::PH_CSI: begin
        if (b >= utfq_pkg::CSI_END_LOW && b <= utfq_pkg::CSI_END_HIGH) begin
          phase_nxt = utfq_pkg::PH_NONE;
        end else begin
          phase_nxt = utfq_pkg::PH_CSI;
        end
      end
      default: begin
        // no escape, and the unused phase code behaves the same
        if (b == utfq_pkg::ESC_BYTE) begin
          phase_nxt = utfq_pkg::PH_ESC;
        end else begin
          pass = (b == utfq_pkg::LINE_FEED) ||
                 (b >= utfq_pkg::PRINT_LOW && b <= utfq_pkg::CSI_END_HIGH);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= utfq_pkg::PH_NONE;
    end else if (req.upd) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/uart_tx_filter_queue.sv @@
// top level: uart transmit queue with escape filter and drain sequencer
`timescale 1ns / 1ps
`default_nettype none

// Transmit queue of a uart driver. Each input item is a text byte write or a
// flush. Items are taken one at a time: a write is accepted, then filtered,
// stored and answered with its result; a drain after a final or rejected byte,
// or a flush, issues the first queue store read, then hands on one byte per
// cycle unless the output stalls, bounded by the smaller of the budget and
// the transmitter room (each saturated at the burst limit) and by the bytes
// queued. A flush that sends nothing gives a single "nothing sent" result.
// The queue lives in one ram with a registered read port; it holds at most
// depth minus one bytes and needs no clearing pass after reset, as only
// written entries are ever read. A new item may be accepted while the last
// result of the previous one still waits in the output register. When the
// channel is disabled every item is answered with "disabled" and no state
// changes. Configuration writes are always taken and are meant for idle time.
module uart_tx_filter_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input items
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_action,
  input  wire logic [utfq_pkg::BYTE_W-1:0]        in_data_byte,
  input  wire logic                               in_final_byte,
  input  wire logic [utfq_pkg::FIELD_W-1:0]       in_budget,
  input  wire logic [utfq_pkg::FIELD_W-1:0]       in_tx_room,
  // result items
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [utfq_pkg::STATUS_W-1:0]      out_status,
  output logic      [utfq_pkg::BYTE_W-1:0]        out_sent_byte,
  output logic      [utfq_pkg::COUNT_W-1:0]       out_queued_count,
  output logic                                    out_last,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [utfq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [utfq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for an item
  localparam logic [1:0] S_EXEC = 2'd1;  // first result, queue store write
  localparam logic [1:0] S_RD   = 2'd2;  // first drain read in flight
  localparam logic [1:0] S_OUT  = 2'd3;  // drained byte ready to hand on

  // pointer helpers, ring of QUEUE_DEPTH entries
  function automatic utfq_pkg::ptr_t adv(input utfq_pkg::ptr_t p);
    return (p == utfq_pkg::PTR_W'(utfq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + utfq_pkg::PTR_W'(1);
  endfunction

  function automatic utfq_pkg::ptr_t fill(input utfq_pkg::ptr_t w, input utfq_pkg::ptr_t r);
    return (w >= r) ? w - r : utfq_pkg::PTR_W'(utfq_pkg::QUEUE_DEPTH) - r + w;
  endfunction

  function automatic logic [utfq_pkg::COUNT_W-1:0] sat_count(input utfq_pkg::ptr_t c);
    return (32'(c) > 255) ? 8'hFF : utfq_pkg::COUNT_W'(c);
  endfunction

  function automatic utfq_pkg::burst_t sat_burst(input logic [utfq_pkg::FIELD_W-1:0] v);
    return (32'(v) > utfq_pkg::MAX_BURST) ? utfq_pkg::BURST_W'(utfq_pkg::MAX_BURST)
                                          : utfq_pkg::BURST_W'(v);
  endfunction

  function automatic utfq_pkg::burst_t min_burst(input utfq_pkg::burst_t a,
                                                 input utfq_pkg::burst_t b);
    return (a < b) ? a : b;
  endfunction

  // configuration registers
  logic                              enabled_r;
  logic [utfq_pkg::CFG_DATA_W-1:0]   auto_budget_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      auto_budget_r <= utfq_pkg::AUTO_BUDGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        utfq_pkg::CFG_ENABLED: enabled_r     <= cfg_data[0];
        utfq_pkg::CFG_BUDGET:  auto_budget_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and pointer state
  logic [1:0]       state_r, state_nxt;
  utfq_pkg::ptr_t   wp_r, wp_nxt;
  utfq_pkg::ptr_t   rp_r, rp_nxt;
  utfq_pkg::burst_t left_r, left_nxt;

  // latched item
  logic             act_r;
  utfq_pkg::byte_t  data_r;
  logic             final_r;
  utfq_pkg::burst_t budget_r;
  utfq_pkg::burst_t room_r;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  utfq_pkg::status_t               out_status_r;
  utfq_pkg::byte_t                 out_sent_byte_r;
  logic [utfq_pkg::COUNT_W-1:0]    out_count_r;
  logic                            out_last_r;

  // result being produced this cycle
  logic                            emit;
  utfq_pkg::status_t               emit_status;
  utfq_pkg::byte_t                 emit_byte;
  logic [utfq_pkg::COUNT_W-1:0]    emit_count;
  logic                            emit_last;

  // queue store ports
  logic             ram_we;
  logic             ram_re;
  utfq_pkg::ptr_t   ram_raddr;
  utfq_pkg::byte_t  ram_rdata;

  // filter
  utfq_pkg::filt_req_t filt_req;
  logic                filt_pass;

  logic             out_free;
  logic             in_acc;
  logic             full;
  utfq_pkg::ptr_t   wp_after;
  utfq_pkg::ptr_t   rp_step;
  utfq_pkg::burst_t n_auto;
  utfq_pkg::burst_t n_flush;
  logic             out_step_last;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign full     = (adv(wp_r) == rp_r);
  assign wp_after = (filt_pass && !full) ? adv(wp_r) : wp_r;
  assign n_auto   = min_burst(sat_burst(auto_budget_r), room_r);
  assign n_flush  = min_burst(budget_r, room_r);

  // drain step: byte at rp leaves the queue
  assign rp_step       = adv(rp_r);
  assign out_step_last = (left_r == utfq_pkg::BURST_W'(1)) || (rp_step == wp_r);

  assign filt_req.data = data_r;
  assign filt_req.upd  = (state_r == S_EXEC) && out_free && enabled_r &&
                         (act_r == utfq_pkg::ACT_WRITE);

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    left_nxt    = left_r;
    emit        = 1'b0;
    emit_status = utfq_pkg::ST_NONE;
    emit_byte   = '0;
    emit_count  = sat_count(fill(wp_r, rp_r));
    emit_last   = 1'b1;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          if (!enabled_r) begin
            emit        = 1'b1;
            emit_status = utfq_pkg::ST_DISABLED;
            state_nxt   = S_IDLE;
          end else if (act_r == utfq_pkg::ACT_FLUSH) begin
            // a flush shows only its sent bytes, or one nothing-sent result
            left_nxt = n_flush;
            if (n_flush == '0 || wp_r == rp_r) begin
              emit        = 1'b1;
              emit_status = utfq_pkg::ST_NONE;
              state_nxt   = S_IDLE;
            end else begin
              state_nxt = S_RD;
            end
          end else begin
            emit       = 1'b1;
            ram_we     = filt_pass && !full;
            wp_nxt     = wp_after;
            left_nxt   = n_auto;
            emit_count = sat_count(fill(wp_after, rp_r));
            if (!filt_pass) begin
              emit_status = utfq_pkg::ST_FILTERED;
            end else if (full) begin
              emit_status = utfq_pkg::ST_REJECTED;
            end else begin
              emit_status = utfq_pkg::ST_QUEUED;
            end
            // final byte or a rejection starts the automatic drain
            if ((final_r || (filt_pass && full)) && n_auto != '0 && wp_after != rp_r) begin
              emit_last = 1'b0;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = utfq_pkg::ST_SENT;
          emit_byte   = ram_rdata;
          emit_count  = sat_count(fill(wp_r, rp_step));
          emit_last   = out_step_last;
          rp_nxt      = rp_step;
          left_nxt    = left_r - utfq_pkg::BURST_W'(1);
          if (out_step_last) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the next byte while this one is handed on
            ram_re    = 1'b1;
            ram_raddr = rp_step;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_action;
      data_r   <= in_data_byte;
      final_r  <= in_final_byte;
      budget_r <= sat_burst(in_budget);
      room_r   <= sat_burst(in_tx_room);
    end
    if (emit) begin
      out_status_r    <= emit_status;
      out_sent_byte_r <= emit_byte;
      out_count_r     <= emit_count;
      out_last_r      <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sent_byte    = out_sent_byte_r;
  assign out_queued_count = out_count_r;
  assign out_last         = out_last_r;

  // a write lands in the ram before any read of that entry is issued, so the ram's
  // registered read sees it without forwarding
  utfq_ram #(
    .DEPTH (utfq_pkg::QUEUE_DEPTH),
    .WIDTH (utfq_pkg::BYTE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (data_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  utfq_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (filt_req),
    .pass  (filt_pass)
  );

  // drain never reads an empty slot
  a_read_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (ram_raddr != wp_r))
    else $error("queue store read beyond write pointer");

  // drain states always have budget left
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_OUT) |-> (left_r != '0))
    else $error("drain running with no budget");

  // the last result of an item returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after last result");

  // read pointer moves only when a byte is handed on
  a_rp_moves_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_OUT) |=> (rp_r == $past(rp_r)))
    else $error("read pointer moved outside a send");

  // nothing is queued while disabled
  a_no_write_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (enabled_r && state_r == S_EXEC && act_r == utfq_pkg::ACT_WRITE))
    else $error("queue store written outside a write item");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench for the uart transmit filter queue: directed and random items checked in order
`timescale 1ns / 1ps

module testbench;
  import utfq_pkg::*;

  // cycles allowed after the last result: a full drain plus the accept and read stages
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 50;
  localparam int PRINT_LIMIT  = 100;

  // one input item as it sits on the in_ ports
  typedef struct packed {
    logic               action;
    byte_t              data_byte;
    logic               final_byte;
    logic [FIELD_W-1:0] budget;
    logic [FIELD_W-1:0] tx_room;
  } tx_item_t;

  // one result item as it sits on the out_ ports
  typedef struct packed {
    status_t            status;
    byte_t              sent_byte;
    logic [COUNT_W-1:0] queued_count;
    logic               last;
  } tx_result_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  in_action     = ACT_WRITE;
  logic [BYTE_W-1:0]     in_data_byte  = '0;
  logic                  in_final_byte = 1'b0;
  logic [FIELD_W-1:0]    in_budget     = '0;
  logic [FIELD_W-1:0]    in_tx_room    = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [BYTE_W-1:0]     out_sent_byte;
  logic [COUNT_W-1:0]    out_queued_count;
  logic                  out_last;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // shadow copy of the transmit queue, escape filter and registers
  byte_t                 shadow_ram [QUEUE_DEPTH];
  int unsigned           shadow_wr;
  int unsigned           shadow_rd;
  phase_t                shadow_phase;
  logic                  shadow_enabled;
  logic [CFG_DATA_W-1:0] shadow_auto_budget;

  // results of the item being predicted, then everything still owed by the block
  tx_result_t item_results [$];
  tx_result_t due_results  [$];

  int unsigned error_count;
  int unsigned items_sent;
  bit          calm;

  uart_tx_filter_queue u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .in_budget        (in_budget),
    .in_tx_room       (in_tx_room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_sent_byte    (out_sent_byte),
    .out_queued_count (out_queued_count),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned fill_level();
    return (shadow_wr + QUEUE_DEPTH - shadow_rd) % QUEUE_DEPTH;
  endfunction

  function automatic int unsigned clip_burst(input int unsigned v);
    return (v > MAX_BURST) ? MAX_BURST : v;
  endfunction

  // queued count is taken after any pointer move of this result
  function automatic tx_result_t make_result(input status_t st, input byte_t b);
    tx_result_t  r;
    int unsigned c;
    c = fill_level();
    if (c > 255) c = 255;
    r.status       = st;
    r.sent_byte    = b;
    r.queued_count = COUNT_W'(c);
    r.last         = 1'b0;
    return r;
  endfunction

  // escape filter: a lone esc swallows the next byte, esc-[ swallows up to a final byte
  function automatic bit filter_pass(input byte_t b);
    if (shadow_phase == PH_ESC) begin
      shadow_phase = (b == CSI_OPEN) ? PH_CSI : PH_NONE;
      return 1'b0;
    end
    if (shadow_phase == PH_CSI) begin
      if (b >= CSI_END_LOW && b <= CSI_END_HIGH) shadow_phase = PH_NONE;
      return 1'b0;
    end
    // any odd phase value counts as no escape
    shadow_phase = PH_NONE;
    if (b == ESC_BYTE) begin
      shadow_phase = PH_ESC;
      return 1'b0;
    end
    return (b == LINE_FEED) || (b >= PRINT_LOW && b <= CSI_END_HIGH);
  endfunction

  // hand queued bytes on, oldest first, one result each
  function automatic void drain_into(input int unsigned limit);
    for (int unsigned n = 0; n < limit && shadow_rd != shadow_wr; n++) begin
      byte_t b;
      b = shadow_ram[shadow_rd];
      shadow_rd = (shadow_rd + 1) % QUEUE_DEPTH;
      item_results.push_back(make_result(ST_SENT, b));
    end
  endfunction

  function automatic void queue_and_drain(input tx_item_t it);
    int unsigned room;
    int unsigned auto_lim;
    int unsigned flush_lim;
    bit          run_drain;
    status_t     st;
    item_results.delete();
    room      = clip_burst(32'(it.tx_room));
    auto_lim  = clip_burst(32'(shadow_auto_budget));
    flush_lim = clip_burst(32'(it.budget));
    if (!shadow_enabled) begin
      item_results.push_back(make_result(ST_DISABLED, '0));
    end else if (it.action == ACT_FLUSH) begin
      drain_into((flush_lim < room) ? flush_lim : room);
      if (item_results.size() == 0) item_results.push_back(make_result(ST_NONE, '0));
    end else begin
      run_drain = it.final_byte;
      if (!filter_pass(it.data_byte)) begin
        st = ST_FILTERED;
      end else if ((shadow_wr + 1) % QUEUE_DEPTH == shadow_rd) begin
        // full queue: reject and drain to make room
        st        = ST_REJECTED;
        run_drain = 1'b1;
      end else begin
        shadow_ram[shadow_wr] = it.data_byte;
        shadow_wr             = (shadow_wr + 1) % QUEUE_DEPTH;
        st                    = ST_QUEUED;
      end
      item_results.push_back(make_result(st, '0));
      if (run_drain) drain_into((auto_lim < room) ? auto_lim : room);
    end
    item_results[item_results.size() - 1].last = 1'b1;
    foreach (item_results[i]) due_results.push_back(item_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < PRINT_LIMIT)
      $display("testbench: mismatch on %s at %0t ns: got %0h, want %0h",
               what, $time, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    tx_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), 0);
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_sent_byte !== want.sent_byte)
          report_mismatch("sent_byte", 32'(out_sent_byte), 32'(want.sent_byte));
        if (out_queued_count !== want.queued_count)
          report_mismatch("queued_count", 32'(out_queued_count), 32'(want.queued_count));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  // receiver back-pressure in bursts, switched off for the calm tail of the run
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // valid stays high after acceptance so a following item can go out back to back
  task automatic send_item(input tx_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= it.action;
    in_data_byte  <= it.data_byte;
    in_final_byte <= it.final_byte;
    in_budget     <= it.budget;
    in_tx_room    <= it.tx_room;
    do @(posedge clk); while (in_stall !== 1'b0);
    queue_and_drain(it);
    items_sent++;
  endtask

  // drop valid, wait for every owed result and let the block fall quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // both registers in one go; spare bits of the enable write carry noise
  task automatic configure(input logic en, input int unsigned auto_budget);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_data  <= CFG_DATA_W'(($urandom_range(0, 15) << 1) | en);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    shadow_enabled = en;
    cfg_index <= CFG_BUDGET;
    cfg_data  <= CFG_DATA_W'(auto_budget);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    shadow_auto_budget = CFG_DATA_W'(auto_budget);
    cfg_valid <= 1'b0;
  endtask

  // unused fields of each kind of item get random values
  function automatic tx_item_t text_byte(input byte_t b, input logic fin,
                                         input int unsigned room);
    tx_item_t it;
    it.action     = ACT_WRITE;
    it.data_byte  = b;
    it.final_byte = fin;
    it.budget     = FIELD_W'($urandom_range(0, 31));
    it.tx_room    = FIELD_W'(room);
    return it;
  endfunction

  function automatic tx_item_t flush_req(input int unsigned budget, input int unsigned room);
    tx_item_t it;
    it.action     = ACT_FLUSH;
    it.data_byte  = byte_t'($urandom_range(0, 255));
    it.final_byte = 1'($urandom_range(0, 1));
    it.budget     = FIELD_W'(budget);
    it.tx_room    = FIELD_W'(room);
    return it;
  endfunction

  // transmitter room: mostly in range, sometimes none, sometimes above the burst limit
  function automatic int unsigned pick_room();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(17, 31);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset the channel is off: everything is refused, nothing moves
  task automatic test_refused_when_disabled();
    send_item(text_byte(8'h41, 1'b1, 16));
    send_item(flush_req(16, 16));
    settle();
    configure(1'b0, 16);
    send_item(text_byte(ESC_BYTE, 1'b0, 31));
    send_item(flush_req(31, 31));
    settle();
  endtask

  // printable range edges, newline, control and high bytes, and escape shapes
  task automatic test_filter_rules();
    byte_t cases [$] = '{8'h41, 8'h20, 8'h7E, 8'h0A, 8'h7F, 8'h00, 8'h1F, 8'hFF, 8'h80,
                         8'h1B, 8'h5B, 8'h33, 8'h6D,          // csi with a parameter
                         8'h1B, 8'h5B, 8'h3F, 8'h40,          // csi ends on lowest final byte
                         8'h1B, 8'h5B, 8'h7E,                 // csi ends on highest final byte
                         8'h1B, 8'h78,                        // esc eats one plain byte
                         8'h1B, 8'h1B, 8'h5B};                // esc eats a second esc
    configure(1'b1, 16);
    foreach (cases[i]) send_item(text_byte(cases[i], 1'b0, pick_room()));
    // newline ends the text and drains with room above the burst limit
    send_item(text_byte(LINE_FEED, 1'b1, 31));
    settle();
  endtask

  // flush bounded by budget, by room and by the bytes waiting
  task automatic test_drain_limits();
    byte_t word [$] = '{8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F};
    send_item(flush_req(31, 31));
    foreach (word[i]) send_item(text_byte(word[i], 1'b0, 0));
    send_item(flush_req(0, 31));
    send_item(flush_req(31, 0));
    send_item(flush_req(2, 31));
    send_item(flush_req(31, 1));
    send_item(flush_req(16, 16));
    send_item(flush_req(5, 5));
    // a filtered final byte still drains
    send_item(text_byte(8'h61, 1'b0, 0));
    send_item(text_byte(8'h62, 1'b0, 0));
    send_item(text_byte(8'h01, 1'b1, 31));
    // final byte with no room sends nothing, so the write result is last
    send_item(text_byte(8'h63, 1'b1, 0));
    send_item(flush_req(31, 31));
    settle();
  endtask

  // automatic drain budget at zero, one, the burst limit and above it
  task automatic test_auto_budget();
    int unsigned settings [$] = '{0, 1, 16, 31};
    foreach (settings[s]) begin
      configure(1'b1, settings[s]);
      repeat (20) send_item(text_byte(byte_t'($urandom_range(8'h21, 8'h7E)), 1'b0, 0));
      send_item(text_byte(LINE_FEED, 1'b1, 31));
      send_item(flush_req(31, 31));
      send_item(flush_req(31, 31));
      settle();
    end
  endtask

  // turning the channel off keeps queue contents and an open escape
  task automatic test_pause_keeps_state();
    configure(1'b1, 16);
    send_item(text_byte(8'h78, 1'b0, 0));
    send_item(text_byte(8'h79, 1'b0, 0));
    send_item(text_byte(ESC_BYTE, 1'b0, 0));
    settle();
    configure(1'b0, 3);
    send_item(text_byte(8'h71, 1'b1, 31));
    send_item(flush_req(31, 31));
    settle();
    configure(1'b1, 16);
    send_item(text_byte(8'h5B, 1'b0, 0));
    send_item(text_byte(8'h4B, 1'b0, 0));
    send_item(text_byte(8'h7A, 1'b1, 31));
    settle();
  endtask

  // fill to depth minus one, then rejections with and without room to drain
  task automatic test_full_queue();
    configure(1'b1, 16);
    while (fill_level() != 0) send_item(flush_req(31, 31));
    while (fill_level() < QUEUE_DEPTH - 1)
      send_item(text_byte(byte_t'($urandom_range(PRINT_LOW, CSI_END_HIGH)), 1'b0, pick_room()));
    send_item(text_byte(8'h5A, 1'b0, 0));
    send_item(text_byte(8'h5A, 1'b0, 5));
    send_item(text_byte(8'h5A, 1'b1, 31));
    while (fill_level() != 0) send_item(flush_req($urandom_range(1, 31), $urandom_range(1, 31)));
    settle();
  endtask

  // one text: mostly printable with newlines and escapes, some raw noise
  task automatic send_random_text();
    byte_t       text [$];
    int unsigned len;
    int unsigned kind;
    logic        ends_text;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        text.push_back(byte_t'($urandom_range(PRINT_LOW, CSI_END_HIGH)));
      end else if (kind < 70) begin
        text.push_back(LINE_FEED);
      end else if (kind < 82) begin
        text.push_back(ESC_BYTE);
        text.push_back(CSI_OPEN);
        repeat ($urandom_range(0, 3)) text.push_back(byte_t'($urandom_range(8'h30, 8'h3F)));
        text.push_back(byte_t'($urandom_range(CSI_END_LOW, CSI_END_HIGH)));
      end else if (kind < 87) begin
        text.push_back(ESC_BYTE);
        text.push_back(byte_t'($urandom_range(0, 255)));
      end else begin
        text.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    ends_text = ($urandom_range(0, 3) != 0);
    foreach (text[i])
      send_item(text_byte(text[i], ends_text && i == text.size() - 1, pick_room()));
  endtask

  // random traffic over several drain settings, the last stretch without idling
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(1'b1, 16);
        1: configure(1'b1, 0);
        2: configure(1'b1, $urandom_range(1, 15));
        3: configure(1'b1, 31);
        default: begin
          calm = 1'b1;
          configure(1'b1, $urandom_range(0, 31));
        end
      endcase
      goal = items_sent + RANDOM_ITEMS / 5;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 75)
          send_random_text();
        else if (pick < 92)
          send_item(flush_req($urandom_range(0, 31), pick_room()));
        else
          send_item(text_byte(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              pick_room()));
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    calm               = 1'b0;
    error_count        = 0;
    items_sent         = 0;
    shadow_wr          = 0;
    shadow_rd          = 0;
    shadow_phase       = PH_NONE;
    shadow_enabled     = 1'b0;
    shadow_auto_budget = AUTO_BUDGET_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_refused_when_disabled();
    test_filter_rules();
    test_drain_limits();
    test_auto_budget();
    test_pause_keeps_state();
    test_full_queue();
    test_random_traffic();

    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ uart_tx_filter_queue.f @@
rtl/utfq_pkg.sv
rtl/utfq_ram.sv
rtl/utfq_filter.sv
rtl/uart_tx_filter_queue.sv
verif/testbench.sv
